>>> rtl/dsv_pkg.sv
package dsv_pkg;

    localparam int MOD_BITS = 32;
    localparam int DIG_BITS = 64;

    typedef logic [MOD_BITS-1:0] word_t;

    // configuration register indexes
    localparam logic [1:0] REG_PRIME_P    = 2'd0;
    localparam logic [1:0] REG_PRIME_Q    = 2'd1;
    localparam logic [1:0] REG_GENERATOR  = 2'd2;
    localparam logic [1:0] REG_PUBLIC_KEY = 2'd3;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RED_S,     // s mod q
        ST_RED_M,     // digest mod q
        ST_INV_DIV,   // t = r0 / r1, r2 = r0 % r1
        ST_INV_MUL,   // prod = t * c1 mod q
        ST_INV_UPD,
        ST_U1,        // u1 = w*m mod q
        ST_U2,        // u2 = w*r mod q
        ST_RED_G,     // g mod p (key mod p in ST_RED_K)
        ST_RED_K,
        ST_EXP_STEP,  // pick next exponent bit
        ST_EXP_MUL,   // acc = acc*base mod p
        ST_EXP_SQR,   // base = base*base mod p
        ST_FIN_MUL,   // a1 * a2 mod p
        ST_FIN_RED,   // mod q
        ST_DONE
    } state_t;

    // shared modular multiplier request/response
    typedef struct packed {
        logic             start;
        logic [DIG_BITS-1:0] a;
        word_t            b;
        word_t            m;
    } mm_req_t;

    typedef struct packed {
        logic  done;
        word_t res;
    } mm_rsp_t;

endpackage

>>> rtl/dsv_modmul.sv
// Bit-serial modular unit: res = (a * b) mod m, one bit of a per cycle once b is below m, MSB first
// (Horner double-and-add). With b = 1 it reduces a. m must be nonzero.
module dsv_modmul (
    input  logic            aclk,
    input  logic            aresetn,
    input  dsv_pkg::mm_req_t req,
    output dsv_pkg::mm_rsp_t rsp
);
    localparam int CW = $clog2(dsv_pkg::DIG_BITS + 1);

    logic [dsv_pkg::DIG_BITS-1:0] a_reg, a_next;
    dsv_pkg::word_t               b_reg, b_next;
    dsv_pkg::word_t               m_reg, m_next;
    dsv_pkg::word_t               acc_reg, acc_next;
    logic [CW-1:0]                cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic                         done_reg, done_next;

    logic [dsv_pkg::MOD_BITS:0]   dbl, dsub, sum, ssub;
    dsv_pkg::word_t               d_red;

    always_comb begin
        // acc*2 mod m, then + b mod m; acc, b < m
        dbl   = {acc_reg, 1'b0};
        dsub  = dbl - {1'b0, m_reg};
        d_red = dbl >= {1'b0, m_reg} ? dsub[dsv_pkg::MOD_BITS-1:0]
                                     : dbl[dsv_pkg::MOD_BITS-1:0];
        sum   = {1'b0, d_red} + {1'b0, b_reg};
        ssub  = sum - {1'b0, m_reg};
        a_next = a_reg; b_next = b_reg; m_next = m_reg; acc_next = acc_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (req.start) begin
            a_next = req.a; m_next = req.m; acc_next = '0;
            b_next = req.b; cnt_next = CW'(dsv_pkg::DIG_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg >= m_reg) begin
                b_next = b_reg - m_reg;   // pre-reduce b (b < 2^32, slow but bounded)
            end else begin
                if (a_reg[dsv_pkg::DIG_BITS-1]) begin
                    acc_next = sum >= {1'b0, m_reg} ? ssub[dsv_pkg::MOD_BITS-1:0]
                                                    : sum[dsv_pkg::MOD_BITS-1:0];
                end else begin
                    acc_next = d_red;
                end
                a_next   = {a_reg[dsv_pkg::DIG_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        a_reg   <= a_next;
        b_reg   <= b_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.res  = acc_reg;

endmodule

>>> rtl/dsa_signature_verifier_unit.sv
// Channel | Valid/Ready         | Payload
// s_      | s_valid / s_ready   | s_digest[63:0], s_sig_r[31:0], s_sig_s[31:0]
// m_      | m_valid / m_ready   | m_valid_res, m_no_inverse
// cfg_    | cfg_valid/cfg_ready | cfg_index[1:0], cfg_data[31:0]
//
// One item at a time: s_ready is high only while the sequencer idles.
// A multiplier pass is a start, one bit step for each of the 64 bits of a, and done. A Euclid
// step is a restoring divide, one multiplier pass and one update state. The worst case is
// 8 single passes, up to 46 Euclid steps and 2 x 32 square/multiply exponent bits.
// Reset (aresetn, synchronous) loads p=7, q=3, g=2, key=1 and idles the sequencer.
// A result waits in the output register while the next item runs; a second one
// holds in DONE until m_ready. cfg_ready is high in idle with no item offered.
module dsa_signature_verifier_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [63:0] s_digest,
    input  logic [31:0] s_sig_r,
    input  logic [31:0] s_sig_s,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_valid_res,
    output logic        m_no_inverse,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    localparam int MB = dsv_pkg::MOD_BITS;
    localparam int DB = dsv_pkg::DIG_BITS;
    localparam int KW = $clog2(MB + 1);

    dsv_pkg::state_t state_reg, state_next;

    dsv_pkg::word_t p_reg, q_reg, g_reg, k_reg;
    logic [DB-1:0]  dig_reg, dig_next;
    dsv_pkg::word_t r_reg, r_next, s_reg, s_next;

    // Euclid state
    dsv_pkg::word_t r0_reg, r0_next, r1_reg, r1_next;
    dsv_pkg::word_t c0_reg, c0_next, c1_reg, c1_next;
    dsv_pkg::word_t t_reg, t_next;
    // divider
    dsv_pkg::word_t rem_reg, rem_next;
    logic [KW-1:0]  dcnt_reg, dcnt_next;
    logic           dbusy_reg, dbusy_next;
    logic [MB:0]    rsh;
    // exponent phase
    dsv_pkg::word_t u1_reg, u1_next, u2_reg, u2_next;
    dsv_pkg::word_t a1_reg, a1_next, a2_reg, a2_next;
    dsv_pkg::word_t base_reg, base_next, acc_reg, acc_next;
    dsv_pkg::word_t e_reg, e_next;
    logic           second_reg, second_next;
    logic           issued_reg, issued_next;

    // verdict of the item in progress
    logic           vwork_reg, vwork_next, nwork_reg, nwork_next;

    logic           mval_reg, mval_next, vres_reg, vres_next, ninv_reg, ninv_next;

    dsv_pkg::mm_req_t mreq;
    dsv_pkg::mm_rsp_t mrsp;

    dsv_modmul u_mm (.aclk(aclk), .aresetn(aresetn), .req(mreq), .rsp(mrsp));

    assign s_ready   = (state_reg == dsv_pkg::ST_IDLE);
    assign cfg_ready = (state_reg == dsv_pkg::ST_IDLE) && !s_valid;
    assign m_valid      = mval_reg;
    assign m_valid_res  = vres_reg;
    assign m_no_inverse = ninv_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsv_pkg::ST_IDLE:
                if (s_valid && s_ready)
                    state_next = (q_reg < MB'(2)) ? dsv_pkg::ST_DONE : dsv_pkg::ST_RED_S;
            dsv_pkg::ST_RED_S:
                if (issued_reg && mrsp.done)
                    state_next = (mrsp.res == '0) ? dsv_pkg::ST_DONE : dsv_pkg::ST_INV_DIV;
            dsv_pkg::ST_INV_DIV:
                if (issued_reg && !dbusy_reg) state_next = dsv_pkg::ST_INV_MUL;
            dsv_pkg::ST_INV_MUL:
                if (issued_reg && mrsp.done) state_next = dsv_pkg::ST_INV_UPD;
            dsv_pkg::ST_INV_UPD:
                if (rem_reg == '0)
                    state_next = (r1_reg == MB'(1)) ? dsv_pkg::ST_RED_M : dsv_pkg::ST_DONE;
                else
                    state_next = dsv_pkg::ST_INV_DIV;
            dsv_pkg::ST_RED_M:
                if (issued_reg && mrsp.done)
                    state_next = (p_reg == '0) ? dsv_pkg::ST_DONE : dsv_pkg::ST_U1;
            dsv_pkg::ST_U1:
                if (issued_reg && mrsp.done) state_next = dsv_pkg::ST_U2;
            dsv_pkg::ST_U2:
                if (issued_reg && mrsp.done) state_next = dsv_pkg::ST_RED_G;
            dsv_pkg::ST_RED_G:
                if (issued_reg && mrsp.done) state_next = dsv_pkg::ST_EXP_STEP;
            dsv_pkg::ST_RED_K:
                if (issued_reg && mrsp.done) state_next = dsv_pkg::ST_EXP_STEP;
            dsv_pkg::ST_EXP_STEP:
                if (e_reg == '0)
                    state_next = second_reg ? dsv_pkg::ST_FIN_MUL : dsv_pkg::ST_RED_K;
                else if (e_reg[0])
                    state_next = dsv_pkg::ST_EXP_MUL;
                else
                    state_next = dsv_pkg::ST_EXP_SQR;
            dsv_pkg::ST_EXP_MUL:
                if (issued_reg && mrsp.done) state_next = dsv_pkg::ST_EXP_SQR;
            dsv_pkg::ST_EXP_SQR:
                if (issued_reg && mrsp.done) state_next = dsv_pkg::ST_EXP_STEP;
            dsv_pkg::ST_FIN_MUL:
                if (issued_reg && mrsp.done) state_next = dsv_pkg::ST_FIN_RED;
            dsv_pkg::ST_FIN_RED:
                if (issued_reg && mrsp.done) state_next = dsv_pkg::ST_DONE;
            dsv_pkg::ST_DONE:
                // wait for the output register to free up
                if (!mval_reg || m_ready) state_next = dsv_pkg::ST_IDLE;
            default: state_next = dsv_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        dig_next = dig_reg; r_next = r_reg; s_next = s_reg;
        r0_next = r0_reg; r1_next = r1_reg; c0_next = c0_reg; c1_next = c1_reg;
        t_next = t_reg; rem_next = rem_reg; dcnt_next = dcnt_reg; dbusy_next = dbusy_reg;
        u1_next = u1_reg; u2_next = u2_reg; a1_next = a1_reg; a2_next = a2_reg;
        base_next = base_reg; acc_next = acc_reg; e_next = e_reg;
        second_next = second_reg;
        issued_next = issued_reg;
        vwork_next = vwork_reg; nwork_next = nwork_reg;
        mval_next = mval_reg; vres_next = vres_reg; ninv_next = ninv_reg;
        mreq = '{start: 1'b0, a: '0, b: MB'(1), m: q_reg};
        rsh = '0;

        if (mval_reg && m_ready) mval_next = 1'b0;

        // request once per multiplier state
        if (!issued_reg) issued_next = 1'b1;
        if (state_next != state_reg) issued_next = 1'b0;

        unique case (state_reg)
            dsv_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    dig_next = s_digest; r_next = s_sig_r; s_next = s_sig_s;
                    vwork_next = 1'b0; nwork_next = (q_reg < MB'(2));
                end
            end
            dsv_pkg::ST_RED_S: begin
                mreq = '{start: !issued_reg, a: DB'(s_reg), b: MB'(1), m: q_reg};
                if (issued_reg && mrsp.done) begin
                    r0_next = q_reg; r1_next = mrsp.res;
                    c0_next = '0; c1_next = MB'(1);
                    nwork_next = (mrsp.res == '0);
                end
            end
            dsv_pkg::ST_INV_DIV: begin
                // restoring divide r0 / r1: quotient in t, remainder in rem
                if (!issued_reg) begin
                    t_next = r0_reg; rem_next = '0;
                    dcnt_next = KW'(MB); dbusy_next = 1'b1;
                end else if (dbusy_reg) begin
                    rsh = {rem_reg, t_reg[MB-1]};
                    if (rsh >= {1'b0, r1_reg}) begin
                        rem_next = MB'(rsh - {1'b0, r1_reg});
                        t_next = {t_reg[MB-2:0], 1'b1};
                    end else begin
                        rem_next = rsh[MB-1:0];
                        t_next = {t_reg[MB-2:0], 1'b0};
                    end
                    dcnt_next = dcnt_reg - KW'(1);
                    if (dcnt_reg == KW'(1)) dbusy_next = 1'b0;
                end
            end
            dsv_pkg::ST_INV_MUL: begin
                mreq = '{start: !issued_reg, a: DB'(t_reg), b: c1_reg, m: q_reg};
                if (issued_reg && mrsp.done)
                    c0_next = (c0_reg >= mrsp.res) ? c0_reg - mrsp.res
                                                   : q_reg - (mrsp.res - c0_reg);
                // c0 now holds c2; swapped in UPD
            end
            dsv_pkg::ST_INV_UPD: begin
                r0_next = r1_reg; r1_next = rem_reg;
                c0_next = c1_reg; c1_next = c0_reg;
                if (rem_reg == '0) begin
                    s_next = c1_reg;   // w
                    nwork_next = (r1_reg != MB'(1));
                end
            end
            dsv_pkg::ST_RED_M: begin
                mreq = '{start: !issued_reg, a: dig_reg, b: MB'(1), m: q_reg};
                if (issued_reg && mrsp.done) dig_next = DB'(mrsp.res);
            end
            dsv_pkg::ST_U1: begin
                mreq = '{start: !issued_reg, a: dig_reg, b: s_reg, m: q_reg};
                if (issued_reg && mrsp.done) u1_next = mrsp.res;
            end
            dsv_pkg::ST_U2: begin
                mreq = '{start: !issued_reg, a: DB'(r_reg), b: s_reg, m: q_reg};
                if (issued_reg && mrsp.done) u2_next = mrsp.res;
            end
            dsv_pkg::ST_RED_G: begin
                mreq = '{start: !issued_reg, a: DB'(g_reg), b: MB'(1), m: p_reg};
                if (issued_reg && mrsp.done) begin
                    base_next = mrsp.res; e_next = u1_reg;
                    acc_next = (p_reg == MB'(1)) ? '0 : MB'(1);
                    second_next = 1'b0;
                end
            end
            dsv_pkg::ST_RED_K: begin
                mreq = '{start: !issued_reg, a: DB'(k_reg), b: MB'(1), m: p_reg};
                if (issued_reg && mrsp.done) begin
                    base_next = mrsp.res; e_next = u2_reg;
                    acc_next = (p_reg == MB'(1)) ? '0 : MB'(1);
                    second_next = 1'b1;
                end
            end
            dsv_pkg::ST_EXP_STEP: begin
                if (e_reg == '0) begin
                    if (second_reg) a2_next = acc_reg;
                    else            a1_next = acc_reg;
                end
            end
            dsv_pkg::ST_EXP_MUL: begin
                mreq = '{start: !issued_reg, a: DB'(acc_reg), b: base_reg, m: p_reg};
                if (issued_reg && mrsp.done) acc_next = mrsp.res;
            end
            dsv_pkg::ST_EXP_SQR: begin
                mreq = '{start: !issued_reg, a: DB'(base_reg), b: base_reg, m: p_reg};
                if (issued_reg && mrsp.done) begin
                    base_next = mrsp.res;
                    e_next = e_reg >> 1;
                end
            end
            dsv_pkg::ST_FIN_MUL: begin
                mreq = '{start: !issued_reg, a: DB'(a1_reg), b: a2_reg, m: p_reg};
                if (issued_reg && mrsp.done) acc_next = mrsp.res;
            end
            dsv_pkg::ST_FIN_RED: begin
                mreq = '{start: !issued_reg, a: DB'(acc_reg), b: MB'(1), m: q_reg};
                if (issued_reg && mrsp.done) vwork_next = (mrsp.res == r_reg);
            end
            dsv_pkg::ST_DONE: begin
                if (!mval_reg || m_ready) begin
                    mval_next = 1'b1;
                    vres_next = vwork_reg;
                    ninv_next = nwork_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= dsv_pkg::ST_IDLE;
            issued_reg <= 1'b0;
            dbusy_reg  <= 1'b0;
            dcnt_reg   <= '0;
            mval_reg   <= 1'b0;
            p_reg <= MB'(7); q_reg <= MB'(3); g_reg <= MB'(2); k_reg <= MB'(1);
        end else begin
            state_reg  <= state_next;
            issued_reg <= issued_next;
            dbusy_reg  <= dbusy_next;
            dcnt_reg   <= dcnt_next;
            mval_reg   <= mval_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    dsv_pkg::REG_PRIME_P:    p_reg <= cfg_data;
                    dsv_pkg::REG_PRIME_Q:    q_reg <= cfg_data;
                    dsv_pkg::REG_GENERATOR:  g_reg <= cfg_data;
                    dsv_pkg::REG_PUBLIC_KEY: k_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
        dig_reg <= dig_next; r_reg <= r_next; s_reg <= s_next;
        r0_reg <= r0_next; r1_reg <= r1_next; c0_reg <= c0_next; c1_reg <= c1_next;
        t_reg <= t_next; rem_reg <= rem_next;
        u1_reg <= u1_next; u2_reg <= u2_next; a1_reg <= a1_next; a2_reg <= a2_next;
        base_reg <= base_next; acc_reg <= acc_next; e_reg <= e_next;
        second_reg <= second_next;
        vwork_reg <= vwork_next; nwork_reg <= nwork_next;
        vres_reg <= vres_next; ninv_reg <= ninv_next;
    end

`ifndef SYNTHESIS
    a_one_hot_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_valid_res && m_no_inverse))
        else $error("valid and no_inverse both set");
    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != dsv_pkg::ST_IDLE) |-> !s_ready)
        else $error("ready while busy");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_valid_res) && $stable(m_no_inverse)))
        else $error("result changed while stalled");
    a_done_raises: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dsv_pkg::ST_DONE) |=> m_valid)
        else $error("done without result");
`endif

endmodule

>>> tb/sv/tb_dsa_signature_verifier_unit.sv
module tb_dsa_signature_verifier_unit;

    // Run limit in cycles. It covers the worst case per item plus the receiver
    // stalls, and leaves a wide margin for about 1350 items.
    localparam longint unsigned CYCLE_LIMIT = 64'd100_000_000;
    localparam int LONG_HOLD = 4000;

    typedef struct {
        logic [63:0] digest;
        logic [31:0] sig_r;
        logic [31:0] sig_s;
    } sig_item_t;

    typedef struct {
        logic valid_res;
        logic no_inverse;
    } verdict_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [63:0] s_digest = '0;
    logic [31:0] s_sig_r = '0;
    logic [31:0] s_sig_s = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_valid_res;
    logic        m_no_inverse;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    dsa_signature_verifier_unit dut (.*);

    always #4 aclk = ~aclk;

    // Local copy of the group and key registers, in sync with the block.
    dsv_pkg::word_t grp_p = 32'd7;
    dsv_pkg::word_t grp_q = 32'd3;
    dsv_pkg::word_t grp_g = 32'd2;
    dsv_pkg::word_t grp_key = 32'd1;

    sig_item_t pending_sigs[$];
    verdict_t  verdicts_due[$];
    int  n_errors = 0;
    int  n_verdicts = 0;
    bit  gaps_on = 1'b0;
    bit  stalls_on = 1'b0;
    longint unsigned n_cycles = 0;

    // ------------------------------------------------------------------
    // Modular arithmetic for the predictor; all moduli fit in 32 bits.
    // ------------------------------------------------------------------
    function automatic longint unsigned mulmod(longint unsigned a, longint unsigned b,
                                               longint unsigned m);
        return ((a % m) * (b % m)) % m;
    endfunction

    function automatic longint unsigned powmod(longint unsigned b, longint unsigned e,
                                               longint unsigned m);
        longint unsigned acc;
        acc = 1 % m;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = mulmod(acc, b, m);
            b = mulmod(b, b, m);
            e = e >> 1;
        end
        return acc;
    endfunction

    // Extended Euclid; returns 0 when a has no inverse modulo m.
    function automatic bit invmod(longint unsigned a, longint unsigned m,
                                  output longint unsigned inv);
        longint unsigned r0, r1, r2, c0, c1, c2, t, prod;
        r0 = m;
        r1 = a % m;
        c0 = 0;
        c1 = 1 % m;
        inv = 0;
        while (r1 != 0) begin
            t = r0 / r1;
            r2 = r0 - t * r1;
            prod = mulmod(t, c1, m);
            c2 = (c0 >= prod) ? c0 - prod : m - (prod - c0);
            r0 = r1;
            r1 = r2;
            c0 = c1;
            c1 = c2;
        end
        inv = c0;
        return r0 == 1;
    endfunction

    function automatic verdict_t predict_verdict(sig_item_t it);
        verdict_t vd;
        longint unsigned w, u1, u2, v;
        vd.valid_res = 1'b0;
        vd.no_inverse = 1'b0;
        if (grp_q < 2 || !invmod(it.sig_s, grp_q, w)) begin
            vd.no_inverse = 1'b1;
        end else if (grp_p != 0) begin
            u1 = mulmod(w, it.digest % grp_q, grp_q);
            u2 = mulmod(w, it.sig_r, grp_q);
            v = mulmod(powmod(grp_g, u1, grp_p), powmod(grp_key, u2, grp_p), grp_p) % grp_q;
            vd.valid_res = (v == it.sig_r);
        end
        return vd;
    endfunction

    function automatic bit prime_ok(longint unsigned n);
        longint unsigned d;
        if (n < 2) return 0;
        if (n % 2 == 0) return n == 2;
        for (d = 3; d * d <= n; d += 2)
            if (n % d == 0) return 0;
        return 1;
    endfunction

    // Honest signature with private exponent x under the current group.
    function automatic sig_item_t sign_digest(logic [63:0] m, longint unsigned x);
        sig_item_t it;
        longint unsigned k, kinv, r;
        bit ok;
        it.digest = m;
        do begin
            k = $urandom_range(grp_q - 1, 1);
            r = powmod(grp_g, k, grp_p) % grp_q;
            ok = invmod(k, grp_q, kinv);
        end while (r == 0 || !ok);
        it.sig_r = 32'(r);
        it.sig_s = 32'(mulmod(kinv, (m % grp_q + mulmod(x, r, grp_q)) % grp_q, grp_q));
        return it;
    endfunction

    function automatic sig_item_t random_item();
        sig_item_t it;
        it.digest = {$urandom, $urandom};
        it.sig_r = $urandom;
        it.sig_s = $urandom;
        return it;
    endfunction

    // Mostly honest signatures when signable, the rest tampered, out-of-range or noise; all noise if not.
    function automatic sig_item_t make_item(bit signable, longint unsigned x);
        sig_item_t it;
        int pick;
        pick = $urandom_range(99);
        if (!signable || pick >= 85) return random_item();
        it = sign_digest({$urandom, $urandom}, x);
        if (pick < 60) return it;
        case ($urandom_range(4))
            0: it.sig_r = it.sig_r + grp_q;               // r above q
            1: it.sig_s = grp_q * $urandom_range(3);       // s zero mod q
            2: it.sig_r = it.sig_r ^ (32'd1 << $urandom_range(31));
            3: it.digest = it.digest + 1;
            default: it.sig_s = it.sig_s + grp_q;          // same s mod q, still valid
        endcase
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Driver: bursts with random gaps when gaps_on; prediction taken at acceptance.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left = 0;

    always @(posedge aclk) begin
        sig_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                it.digest = s_digest;
                it.sig_r = s_sig_r;
                it.sig_s = s_sig_s;
                verdicts_due.push_back(predict_verdict(it));
            end
            if (!s_valid || s_ready) begin
                if (gap_left > 0 || pending_sigs.size() == 0) begin
                    s_valid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                end else begin
                    it = pending_sigs.pop_front();
                    s_digest <= it.digest;
                    s_sig_r <= it.sig_r;
                    s_sig_s <= it.sig_s;
                    s_valid <= 1'b1;
                    if (--burst_left <= 0) begin
                        burst_left = $urandom_range(8, 1);
                        gap_left = gaps_on ? $urandom_range(30) : 0;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compares each result item with the oldest prediction.
    // ------------------------------------------------------------------
    int hold_left = 0;

    always @(posedge aclk) begin
        verdict_t exp_vd;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_verdicts++;
                if (verdicts_due.size() == 0) begin
                    $display("%0t: result item with none expected: valid_res %0b no_inverse %0b",
                             $time, m_valid_res, m_no_inverse);
                    n_errors++;
                end else begin
                    exp_vd = verdicts_due.pop_front();
                    if (m_valid_res !== exp_vd.valid_res) begin
                        $display("%0t: valid_res mismatch: expected %0b actual %0b",
                                 $time, exp_vd.valid_res, m_valid_res);
                        n_errors++;
                    end
                    if (m_no_inverse !== exp_vd.no_inverse) begin
                        $display("%0t: no_inverse mismatch: expected %0b actual %0b",
                                 $time, exp_vd.no_inverse, m_no_inverse);
                        n_errors++;
                    end
                end
                // one long hold-off while the sender keeps offering
                if (n_verdicts == 40) hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= stalls_on ? ($urandom_range(3) != 0) : 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("tb_dsa_signature_verifier_unit: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequencing
    // ------------------------------------------------------------------
    // Leaves cfg_valid high so writes can follow back to back.
    task automatic write_reg(logic [1:0] idx, dsv_pkg::word_t val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            dsv_pkg::REG_PRIME_P:    grp_p = val;
            dsv_pkg::REG_PRIME_Q:    grp_q = val;
            dsv_pkg::REG_GENERATOR:  grp_g = val;
            default:                 grp_key = val;
        endcase
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (pending_sigs.size() != 0 || s_valid || verdicts_due.size() != 0);
        repeat (20) @(posedge aclk);
    endtask

    task automatic run_phase(dsv_pkg::word_t p, dsv_pkg::word_t q, dsv_pkg::word_t g,
                             dsv_pkg::word_t key, bit signable,
                             longint unsigned x, int n_items);
        write_reg(dsv_pkg::REG_PRIME_P, p);
        write_reg(dsv_pkg::REG_PRIME_Q, q);
        write_reg(dsv_pkg::REG_GENERATOR, g);
        write_reg(dsv_pkg::REG_PUBLIC_KEY, key);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        gaps_on = 1'($urandom_range(1));
        stalls_on = 1'($urandom_range(1));
        repeat (n_items) pending_sigs.push_back(make_item(signable, x));
        wait_drained();
    endtask

    function automatic longint unsigned find_group_q(longint unsigned lo, longint unsigned hi);
        longint unsigned q;
        q = lo + ({$urandom, $urandom} % (hi - lo)) | 1;
        while (!(prime_ok(q) && prime_ok(2 * q + 1))) q += 2;
        return q;
    endfunction

    initial begin
        sig_item_t it;
        longint unsigned q_sm, q_big, x_sm, x_big;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed items under the reset group p=7, q=3, g=2, key=1 (x=0).
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        it = '{64'd0, 32'd0, 32'd0};                pending_sigs.push_back(it);
        it = '{'1, '1, '1};                         pending_sigs.push_back(it);
        it = '{64'd5, 32'd1, 32'd3};                pending_sigs.push_back(it); // s zero mod q
        it = '{64'd5, 32'd2, 32'hFFFF_FFFF};        pending_sigs.push_back(it);
        it = '{64'd0, 32'd3, 32'd1};                pending_sigs.push_back(it); // r equal to q
        it = '{'1, 32'd1, 32'd1};                   pending_sigs.push_back(it);
        it = sign_digest(64'd0, 0);                 pending_sigs.push_back(it);
        it = sign_digest('1, 0);                    pending_sigs.push_back(it);
        it = sign_digest(64'h8000_0000_0000_0001, 0); pending_sigs.push_back(it);
        it = it; it.sig_r = it.sig_r + 3;           pending_sigs.push_back(it); // r above q
        it = '{64'h5555_5555_5555_5555, 32'hAAAA_AAAA, 32'h5555_5555};
        pending_sigs.push_back(it);
        it = '{64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
        pending_sigs.push_back(it);
        wait_drained();
        run_phase(32'd7, 32'd3, 32'd2, 32'd1, 1'b1, 0, 60);

        // Safe-prime groups p = 2q + 1 with generator 4 of order q.
        q_sm = find_group_q(64'd1000, 64'd60000);
        q_big = find_group_q(64'h4000_0000, 64'h7FFF_FF00);
        x_sm = $urandom_range(32'(q_sm - 1), 1);
        x_big = $urandom_range(32'(q_big - 1), 1);
        run_phase(32'd23, 32'd11, 32'd4, 32'(powmod(4, 7, 23)), 1'b1, 7, 150);
        run_phase(32'(2 * q_sm + 1), 32'(q_sm), 32'd4, 32'(powmod(4, x_sm, 2 * q_sm + 1)),
                  1'b1, x_sm, 250);
        run_phase(32'(2 * q_big + 1), 32'(q_big), 32'd4,
                  32'(powmod(4, x_big, 2 * q_big + 1)), 1'b1, x_big, 300);

        // Degenerate and extreme register settings.
        run_phase(32'd0, 32'd11, 32'd4, 32'd9, 1'b0, 0, 70);          // p zero
        run_phase(32'd1, 32'd5, 32'd3, 32'd7, 1'b0, 0, 70);           // p one
        run_phase(32'd23, 32'd0, 32'd4, 32'd2, 1'b0, 0, 40);          // q zero
        run_phase(32'd23, 32'd1, 32'd4, 32'd2, 1'b0, 0, 40);          // q one
        run_phase(32'd31, 32'd15, 32'd2, 32'd8, 1'b0, 0, 100);        // composite q
        run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFB, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 0, 60);
        run_phase(32'hFFFF_FFFB, 32'd2, 32'd0, 32'd0, 1'b0, 0, 60);
        // smallest group: every r comes out zero, so no honest signature exists
        run_phase(32'd3, 32'd2, 32'd2, 32'd2, 1'b0, 1, 120);

        if (n_errors == 0) begin
            $display("tb_dsa_signature_verifier_unit: PASS");
        end else begin
            $display("tb_dsa_signature_verifier_unit: FAIL");
        end
        $finish;
    end

endmodule
